// ----- design/ffha_pkg.sv -----
// Shared types, constants and helpers for the first-fit heap allocator
package ffha_pkg;

  localparam int MaxBlocks   = 64;
  localparam int HeaderBytes = 12;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_INIT  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADPTR  = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LEFT  = 2'd1,
    CMD_RIGHT = 2'd2,
    CMD_SET   = 2'd3
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_MERGE = 2'd2,
    S_DONE  = 2'd3
  } fsm_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } ent_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } pick_t;

  function automatic pick_t first_set(input logic [MaxBlocks-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int j = MaxBlocks - 1; j >= 0; j--) begin
      if (v[j]) begin
        p.found = 1'b1;
        p.idx   = IdxW'(j);
      end
    end
    return p;
  endfunction

endpackage

// ----- design/ffha_cell.sv -----
// One table entry of the block chain: holds a block and shifts with its neighbours
module ffha_cell (
  input  logic              clk,
  input  ffha_pkg::cell_cmd_t cmd,
  input  ffha_pkg::ent_t    left_i,
  input  ffha_pkg::ent_t    right_i,
  input  ffha_pkg::ent_t    set_i,
  input  logic              valid_i,
  input  logic [32:0]       need_i,
  input  logic [31:0]       ptr_i,
  output ffha_pkg::ent_t    ent_o,
  output logic              fit_o,
  output logic              hit_o
);
  import ffha_pkg::*;

  ent_t ent_r, ent_nxt;

  always_comb begin
    unique case (cmd)
      CMD_HOLD:  ent_nxt = ent_r;
      CMD_LEFT:  ent_nxt = left_i;
      CMD_RIGHT: ent_nxt = right_i;
      CMD_SET:   ent_nxt = set_i;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o = ent_r;
  assign fit_o = valid_i && ent_r.free && ({1'b0, ent_r.size} >= need_i);
  assign hit_o = valid_i && ((ent_r.start + 32'(HeaderBytes)) == ptr_i);

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: sequencer, totals and the cell chain
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_func, in_request_size, in_pointer
//   out     | output    | out_valid, out_ready, out_addr, out_status, out_used_bytes,
//           |           | out_free_bytes, out_blocks_in_use
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata
//
// Allocate, init, null or unknown free and func 3 pass through EXEC and then DONE after
// the transfer; a matching free passes EXEC, then MERGE, one merge per step, each a chain
// shift, until no free pair is left, then DONE. The next transfer is taken back in IDLE.
// Search over all cells is a combinational priority pick.
// Reset clears the block count, heap_base to 0 and heap_size to 65536.
// A pending result in the output register stalls only the final step.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_pointer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_addr,
  output logic [1:0]  out_status,
  output logic [31:0] out_used_bytes,
  output logic [31:0] out_free_bytes,
  output logic [ffha_pkg::CntW-1:0] out_blocks_in_use,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ffha_pkg::*;

  fsm_t        state_r, state_nxt;
  logic [31:0] base_r, hsize_r;
  logic [1:0]  func_r;
  logic [31:0] req_r, ptr_r;
  logic [32:0] need;
  logic [CntW-1:0] count_r, count_nxt;
  logic [31:0] used_r, used_nxt, freeb_r, freeb_nxt;
  logic [31:0] addr_r, addr_nxt;
  status_t     stat_r, stat_nxt;
  logic        ov_r;
  logic [31:0] o_addr_r, o_used_r, o_free_r;
  logic [1:0]  o_stat_r;
  logic [CntW-1:0] o_cnt_r;

  ent_t        ent [MaxBlocks];
  ent_t        set_v [MaxBlocks];
  cell_cmd_t   cmd [MaxBlocks];
  logic [MaxBlocks-1:0] valid, fit, hit, pair;
  pick_t       p_fit, p_hit, p_pair;
  ent_t        ek, ek1;
  logic        split;
  logic [31:0] rest;

  assign need = ({1'b0, req_r} + 33'd3) & ~33'd3;

  for (genvar j = 0; j < MaxBlocks; j++) begin : g_cell
    ffha_cell u_cell (
      .clk     (clk),
      .cmd     (cmd[j]),
      .left_i  (ent[(j == 0) ? 0 : j - 1]),
      .right_i (ent[(j == MaxBlocks - 1) ? j : j + 1]),
      .set_i   (set_v[j]),
      .valid_i (valid[j]),
      .need_i  (need),
      .ptr_i   (ptr_r),
      .ent_o   (ent[j]),
      .fit_o   (fit[j]),
      .hit_o   (hit[j])
    );
    assign valid[j] = (CntW'(j) < count_r);
    if (j < MaxBlocks - 1) begin : g_pair
      assign pair[j] = valid[j+1] && ent[j].free && ent[j+1].free;
    end else begin : g_last
      assign pair[j] = 1'b0;
    end
  end

  assign p_fit  = first_set(fit);
  assign p_hit  = first_set(hit);
  assign p_pair = first_set(pair);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    freeb_nxt = freeb_r;
    addr_nxt  = addr_r;
    stat_nxt  = stat_r;
    ek        = ent[p_fit.idx];
    ek1       = ent[(p_pair.idx == IdxW'(MaxBlocks - 1)) ? p_pair.idx : p_pair.idx + 1'b1];
    split     = ({2'b0, ek.size} >= ({1'b0, need} + 34'(HeaderBytes + 4)))
                && (count_r < CntW'(MaxBlocks));
    rest      = ek.size - need[31:0] - 32'(HeaderBytes);
    for (int j = 0; j < MaxBlocks; j++) begin
      cmd[j]   = CMD_HOLD;
      set_v[j] = ent[j];
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        addr_nxt  = '0;
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
        unique case (func_r)
          FUNC_INIT: begin
            cmd[0]   = CMD_SET;
            set_v[0] = '{start: base_r,
                         size: (hsize_r >= 32'(HeaderBytes)) ?
                               hsize_r - 32'(HeaderBytes) : '0,
                         free: 1'b1};
            count_nxt = CntW'(1);
            used_nxt  = '0;
            freeb_nxt = set_v[0].size;
          end
          FUNC_ALLOC: begin
            if (!p_fit.found) begin
              stat_nxt = ST_NOMEM;
            end else begin
              addr_nxt = ek.start + 32'(HeaderBytes);
              cmd[p_fit.idx] = CMD_SET;
              set_v[p_fit.idx] = '{start: ek.start,
                                   size: split ? need[31:0] : ek.size, free: 1'b0};
              if (split) begin
                for (int j = 0; j < MaxBlocks; j++) begin
                  if (IdxW'(j) > p_fit.idx + 1'b1 && j > 0) cmd[j] = CMD_LEFT;
                end
                cmd[p_fit.idx + 1'b1]   = CMD_SET;
                set_v[p_fit.idx + 1'b1] = '{start: ek.start + 32'(HeaderBytes) + need[31:0],
                                            size: rest, free: 1'b1};
                count_nxt = count_r + 1'b1;
                used_nxt  = used_r + need[31:0];
                freeb_nxt = freeb_r - ek.size + rest;
              end else begin
                used_nxt  = used_r + ek.size;
                freeb_nxt = freeb_r - ek.size;
              end
            end
          end
          FUNC_FREE: begin
            if (ptr_r != '0) begin
              if (!p_hit.found) begin
                stat_nxt = ST_BADPTR;
              end else begin
                cmd[p_hit.idx]        = CMD_SET;
                set_v[p_hit.idx].free = 1'b1;
                if (!ent[p_hit.idx].free) begin
                  used_nxt  = used_r - ent[p_hit.idx].size;
                  freeb_nxt = freeb_r + ent[p_hit.idx].size;
                end
                state_nxt = S_MERGE;
              end
            end
          end
          default: ;
        endcase
      end
      S_MERGE: begin
        if (p_pair.found) begin
          cmd[p_pair.idx]        = CMD_SET;
          set_v[p_pair.idx].size = ent[p_pair.idx].size + 32'(HeaderBytes) + ek1.size;
          for (int j = 0; j < MaxBlocks - 1; j++) begin
            if (IdxW'(j) > p_pair.idx) cmd[j] = CMD_RIGHT;
          end
          count_nxt = count_r - 1'b1;
          freeb_nxt = freeb_r + 32'(HeaderBytes);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      base_r  <= '0;
      hsize_r <= 32'd65536;
      used_r  <= '0;
      freeb_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
      freeb_r <= freeb_nxt;
      if (cfg_we) begin
        if (cfg_index) hsize_r <= cfg_wdata;
        else           base_r  <= cfg_wdata;
      end
      if (state_r == S_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready)                             ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    stat_r <= stat_nxt;
    if (in_valid && in_ready) begin
      func_r <= in_func;
      req_r  <= in_request_size;
      ptr_r  <= in_pointer;
    end
    if (state_r == S_DONE && (!ov_r || out_ready)) begin
      o_addr_r <= addr_r;
      o_stat_r <= stat_r;
      o_used_r <= used_r;
      o_free_r <= freeb_r;
      o_cnt_r  <= count_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_addr          = o_addr_r;
  assign out_status        = o_stat_r;
  assign out_used_bytes    = o_used_r;
  assign out_free_bytes    = o_free_r;
  assign out_blocks_in_use = o_cnt_r;

endmodule

// ----- verif/tb_first_fit_heap_allocator.sv -----
// Testbench for the first-fit heap allocator: directed and random traffic checked against a block-table predictor
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int IdleLimit = 20000;

  typedef struct {
    func_t       func;
    logic [31:0] req;
    logic [31:0] ptr;
  } heap_op_t;

  typedef struct {
    logic [31:0]     addr;
    status_t         status;
    logic [31:0]     used;
    logic [31:0]     freeb;
    logic [CntW-1:0] count;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_pointer = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_addr;
  logic [1:0] out_status;
  logic [31:0] out_used_bytes;
  logic [31:0] out_free_bytes;
  logic [CntW-1:0] out_blocks_in_use;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  first_fit_heap_allocator u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] m_base = 32'd0;
  logic [31:0] m_size = 32'd65536;
  logic [31:0] t_start [MaxBlocks];
  logic [31:0] t_size [MaxBlocks];
  logic        t_free [MaxBlocks];
  int          t_count = 0;
  logic [31:0] live_ptrs[$];

  heap_op_t  pending_ops[$];
  heap_res_t expected_res[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  int gap = 0;
  int stall = 0;
  bit in_taken = 1'b0;

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  function automatic heap_res_t predict_heap(heap_op_t op);
    heap_res_t r;
    logic [32:0] need;
    int k;
    int f;
    r.addr = '0;
    r.status = ST_OK;
    case (op.func)
      FUNC_ALLOC: begin
        need = ({1'b0, op.req} + 33'd3) & ~33'd3;
        f = -1;
        for (k = 0; k < t_count; k++)
          if (f < 0 && t_free[k] && {1'b0, t_size[k]} >= need) f = k;
        if (f < 0) r.status = ST_NOMEM;
        else begin
          if ({1'b0, t_size[f]} >= need + 33'(HeaderBytes + 4) && t_count < MaxBlocks) begin
            for (k = t_count; k > f + 1; k--) begin
              t_start[k] = t_start[k-1];
              t_size[k] = t_size[k-1];
              t_free[k] = t_free[k-1];
            end
            t_start[f+1] = t_start[f] + 32'(HeaderBytes) + need[31:0];
            t_size[f+1] = t_size[f] - need[31:0] - 32'(HeaderBytes);
            t_free[f+1] = 1'b1;
            t_count++;
            t_size[f] = need[31:0];
          end
          t_free[f] = 1'b0;
          r.addr = t_start[f] + 32'(HeaderBytes);
          live_ptrs.push_back(r.addr);
        end
      end
      FUNC_FREE: if (op.ptr != 0) begin
        f = -1;
        for (k = 0; k < t_count; k++)
          if (f < 0 && t_start[k] + 32'(HeaderBytes) == op.ptr) f = k;
        if (f < 0) r.status = ST_BADPTR;
        else begin
          t_free[f] = 1'b1;
          k = 0;
          while (k + 1 < t_count) begin
            if (t_free[k] && t_free[k+1]) begin
              t_size[k] = t_size[k] + 32'(HeaderBytes) + t_size[k+1];
              for (int j = k + 1; j + 1 < t_count; j++) begin
                t_start[j] = t_start[j+1];
                t_size[j] = t_size[j+1];
                t_free[j] = t_free[j+1];
              end
              t_count--;
            end else k++;
          end
        end
      end
      FUNC_INIT: begin
        t_start[0] = m_base;
        t_size[0] = (m_size >= HeaderBytes) ? m_size - 32'(HeaderBytes) : 32'd0;
        t_free[0] = 1'b1;
        t_count = 1;
        live_ptrs.delete();
      end
      default: ;
    endcase
    r.used = '0;
    r.freeb = '0;
    for (k = 0; k < t_count; k++)
      if (t_free[k]) r.freeb += t_size[k];
      else r.used += t_size[k];
    r.count = CntW'(t_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%08h expected 0x%08h", n_recv, what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_valid <= 1'b0;
        gap = rand_gap();
      end else if (!in_valid) begin
        if (gap > 0) gap--;
        else if (pending_ops.size() > 0) begin
          heap_op_t op;
          op = pending_ops.pop_front();
          in_func <= op.func;
          in_request_size <= op.req;
          in_pointer <= op.ptr;
          in_valid <= 1'b1;
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = rand_gap();
      end
    end
  end

  // prediction on input transfer, check on output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        heap_op_t op;
        op.func = func_t'(in_func);
        op.req = in_request_size;
        op.ptr = in_pointer;
        expected_res.push_back(predict_heap(op));
        n_sent++;
        idle_cycles = 0;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        heap_res_t e;
        idle_cycles = 0;
        n_recv++;
        if (expected_res.size() == 0) begin
          $display("MISMATCH unexpected result %0d", n_recv);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (out_addr !== e.addr) report_mismatch("addr", out_addr, e.addr);
          if (out_status !== e.status) report_mismatch("status", 32'(out_status), 32'(e.status));
          if (out_used_bytes !== e.used) report_mismatch("used", out_used_bytes, e.used);
          if (out_free_bytes !== e.freeb) report_mismatch("free", out_free_bytes, e.freeb);
          if (out_blocks_in_use !== e.count)
            report_mismatch("blocks", 32'(out_blocks_in_use), 32'(e.count));
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d results outstanding", expected_res.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_req();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 8);
      2: return 32'd0;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  function automatic logic [31:0] rand_ptr();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      default: return m_base + 32'(HeaderBytes) + 32'($urandom_range(0, 1500) * 4);
    endcase
  endfunction

  task automatic add_op(func_t f, logic [31:0] req, logic [31:0] ptr);
    heap_op_t op;
    op.func = f;
    op.req = req;
    op.ptr = ptr;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == 1'b0) m_base = val;
    else m_size = val;
  endtask

  initial begin
    int phase;
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: before init, extremes, null and bad frees, double free, func 3
    add_op(FUNC_ALLOC, 32'd4, 32'd0);
    add_op(FUNC_FREE, 32'd0, 32'hFFFF_FFFF);
    add_op(FUNC_FREE, 32'd0, 32'd0);
    add_op(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(FUNC_INIT, 32'd0, 32'd0);
    add_op(FUNC_ALLOC, 32'd0, 32'd0);
    add_op(FUNC_ALLOC, 32'd1, 32'd0);
    add_op(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
    add_op(FUNC_ALLOC, 32'hFFFF_FFFD, 32'd0);
    add_op(FUNC_ALLOC, 32'd100, 32'd0);
    add_op(FUNC_FREE, 32'd0, 32'd12);
    add_op(FUNC_FREE, 32'd0, 32'd12);
    add_op(FUNC_FREE, 32'd0, 32'd13);
    add_op(FUNC_FREE, 32'd0, 32'd24);
    add_op(FUNC_ALLOC, 32'd65524, 32'd0);
    add_op(FUNC_ALLOC, 32'd4, 32'd0);
    wait_drained();

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin write_cfg(1'b0, 32'd0); write_cfg(1'b1, 32'd4096); end
        1: begin write_cfg(1'b0, 32'hFFFF_FF00); write_cfg(1'b1, 32'd2048); end
        2: begin write_cfg(1'b0, 32'hFFFF_FFFF); write_cfg(1'b1, 32'd16); end
        3: begin write_cfg(1'b0, $urandom()); write_cfg(1'b1, 32'hFFFF_FFFF); end
        4: begin write_cfg(1'b0, 32'h1000_0000); write_cfg(1'b1, 32'd20000); end
        5: begin write_cfg(1'b0, 32'd0); write_cfg(1'b1, 32'd12); end
        default: begin write_cfg(1'b0, 32'h0000_8000); write_cfg(1'b1, 32'd3000); end
      endcase
      add_op(FUNC_INIT, $urandom(), $urandom());
      n = (phase == 6) ? 650 : 215;
      for (int i = 0; i < n; i++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) add_op(FUNC_ALLOC, rand_req(), $urandom());
        else if (r < 90) begin
          // frees mostly hit live blocks; predictor tracks them at issue time
          while (pending_ops.size() > 0 || in_valid) @(posedge clk);
          if (live_ptrs.size() > 0 && $urandom_range(0, 3) != 0) begin
            int j;
            j = $urandom_range(0, live_ptrs.size() - 1);
            add_op(FUNC_FREE, $urandom(), live_ptrs[j]);
            live_ptrs.delete(j);
          end else add_op(FUNC_FREE, $urandom(), rand_ptr());
        end else if (r < 97) add_op(FUNC_NONE, $urandom(), $urandom());
        else add_op(FUNC_INIT, $urandom(), $urandom());
      end
      wait_drained();
    end

    $display("Sent %0d operations over 8 heap settings, %0d results checked", n_sent, n_recv);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
